@@ hw/rtl/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bsd_pkg
// shared types and constants for the byte stuffing deframer
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int MAX_FRAME = 4096;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = $clog2(MAX_FRAME + 1);
    localparam int CNT_W     = $clog2(MAX_FRAME);

    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] START_CODE = 8'h00;
    localparam logic [BYTE_W-1:0] END_CODE   = 8'h01;

    localparam logic [LEN_W-1:0] LIMIT_MAX   = LEN_W'(MAX_FRAME);
    localparam logic [LEN_W-1:0] LIMIT_MIN   = LEN_W'(1);
    localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(MAX_FRAME);

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_RESTART  = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  payload;
        logic [CNT_W-1:0]   slot;
        logic [LEN_W-1:0]   frame_length;
    } t_result;

endpackage

@@ hw/rtl/bsd_in_stage.sv @@
// ----------------------------------------------------------------------------
// bsd_in_stage
// input register: holds one received byte until the decoder consumes it
// ----------------------------------------------------------------------------
module bsd_in_stage
    import bsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_consume,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ hw/rtl/bsd_decode.sv @@
// ----------------------------------------------------------------------------
// bsd_decode
// escape flag and frame counter, decodes one byte into at most one result
// ----------------------------------------------------------------------------
module bsd_decode
    import bsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_consume,
    input  logic [LEN_W-1:0]  i_frame_limit,
    output logic              o_has_result,
    output t_result           o_result
);

    logic             r_esc;
    logic [CNT_W-1:0] r_cnt;
    logic             n_esc;
    logic [CNT_W-1:0] n_cnt;
    logic [LEN_W-1:0] eff_limit;
    logic [LEN_W-1:0] len;
    logic             is_data;

    // clamp the limit into 1 .. max frame
    always_comb begin
        eff_limit = i_frame_limit;
        if (i_frame_limit < LIMIT_MIN) begin
            eff_limit = LIMIT_MIN;
        end else if (i_frame_limit > LIMIT_MAX) begin
            eff_limit = LIMIT_MAX;
        end
    end

    assign len = {1'b0, r_cnt} + LEN_W'(1);

    always_comb begin
        n_esc        = r_esc;
        n_cnt        = r_cnt;
        is_data      = 1'b0;
        o_has_result = 1'b0;
        o_result     = '{kind: KIND_PAYLOAD, payload: '0, slot: '0, frame_length: '0};
        if (r_esc) begin
            n_esc = 1'b0;
            if (i_byte == START_CODE) begin
                n_cnt         = '0;
                o_has_result  = 1'b1;
                o_result.kind = KIND_RESTART;
            end else if (i_byte == END_CODE) begin
                o_has_result          = 1'b1;
                o_result.kind         = KIND_DONE;
                o_result.frame_length = {1'b0, r_cnt};
            end else begin
                is_data = 1'b1;
            end
        end else if (i_byte == ESC_BYTE) begin
            n_esc = 1'b1;
        end else begin
            is_data = 1'b1;
        end

        if (is_data) begin
            o_has_result          = 1'b1;
            o_result.payload      = i_byte;
            o_result.slot         = r_cnt;
            o_result.frame_length = len;
            if (len >= eff_limit) begin
                o_result.kind = KIND_OVERFLOW;
                n_cnt         = '0;
                n_esc         = 1'b0;
            end else begin
                o_result.kind = KIND_PAYLOAD;
                n_cnt         = len[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_cnt <= '0;
        end else if (i_consume) begin
            r_esc <= n_esc;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/bsd_out_stage.sv @@
// ----------------------------------------------------------------------------
// bsd_out_stage
// result register: holds a decoded result until the receiver takes it
// ----------------------------------------------------------------------------
module bsd_out_stage
    import bsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hw/rtl/byte_stuff_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// byte_stuff_deframer_unit
// escape byte deframer: one received serial byte in, at most one result out
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready carry i_rx_byte, one byte a request.
// output channel: o_out_valid / i_out_ready carry kind, payload, slot and
//   frame_length. an escape byte (255) yields no result; escape+0 restarts
//   the frame, escape+1 reports the frame length, every other byte is data.
// config channel: i_cfg_valid / o_cfg_ready write frame_limit, always ready;
//   write it only while the unit is idle.
// path: an accepted byte enters the input register, then is decoded
//   into the result register.
// throughput: one byte per cycle while the receiver takes results; the
//   decode stage updates the escape flag and frame counter once per byte.
// reset: escape flag and count cleared, frame_limit back to 4096, both
//   pipeline registers empty.
// receiver stall: the result register holds; the input register takes
//   bytes until one with a result waits; o_in_ready stays low till drained.
// ----------------------------------------------------------------------------
module byte_stuff_deframer_unit
    import bsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [BYTE_W-1:0] o_payload,
    output logic [CNT_W-1:0]  o_slot,
    output logic [LEN_W-1:0]  o_frame_length,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_frame_limit
);

    logic [LEN_W-1:0]  r_frame_limit;
    logic              stg_valid;
    logic [BYTE_W-1:0] stg_byte;
    logic              consume;
    logic              has_result;
    logic              out_free;
    t_result           dec_result;
    t_result           out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_frame_limit <= i_cfg_frame_limit;
        end
    end

    // an escape byte has no result and never waits on the output
    assign consume = stg_valid && (!has_result || out_free);

    bsd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_byte    (i_rx_byte),
        .i_consume (consume),
        .o_valid   (stg_valid),
        .o_byte    (stg_byte)
    );

    bsd_decode u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte        (stg_byte),
        .i_consume     (consume),
        .i_frame_limit (r_frame_limit),
        .o_has_result  (has_result),
        .o_result      (dec_result)
    );

    bsd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (consume && has_result),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_kind         = out_result.kind;
    assign o_payload      = out_result.payload;
    assign o_slot         = out_result.slot;
    assign o_frame_length = out_result.frame_length;

endmodule
